### rtl/overdamping_constant_from_stiffness_macros.svh
// assertion macros for the overdamping constant block
`ifndef OVERDAMPING_CONSTANT_FROM_STIFFNESS_MACROS_SVH
`define OVERDAMPING_CONSTANT_FROM_STIFFNESS_MACROS_SVH

// same-cycle implication
`define ODC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("odc assertion failed");

// next-cycle implication
`define ODC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("odc assertion failed");

`endif

### rtl/odc_pkg.sv
// package: constants and types of the overdamping constant block
`timescale 1ns / 1ps
package odc_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam logic [31:0] STIFF_INF = 32'hFFFF_FFFF;
   localparam logic [31:0] MIN_STIFF_RESET = 32'd256;

   // csr map
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_MIN_STIFFNESS = 1'b0;

   // criterion codes
   localparam logic [1:0] FUNC_BENADY  = 2'd0;
   localparam logic [1:0] FUNC_HINF    = 2'd1;
   localparam logic [1:0] FUNC_SPR     = 2'd2;
   localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

   // status codes
   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_JOINT  = 3'd1;
   localparam logic [2:0] ST_DEVICE = 3'd2;
   localparam logic [2:0] ST_ENV    = 3'd3;
   localparam logic [2:0] ST_TARGET = 3'd4;
   localparam logic [2:0] ST_FUNC   = 3'd5;

   // control word that travels with each item
   typedef struct packed {
      logic       valid;
      logic [1:0] func;
      logic [2:0] status;
      logic       any_zero;
      logic       comb_inf;
      logic       t_inf;
      logic       t_zero;
   } ctl_type;

endpackage

### rtl/overdamping_constant_from_stiffness.sv
// overdamping constant from stiffness
// one item accepted per cycle, busy is never raised, one result per item
// the pipeline holds the 64-stage series-stiffness divider, the (33 + 2*FRAC_BITS)-stage
// kappa divider and the 34-stage square root, one bit per stage
// synchronous active-high reset clears valid bits and sets min_stiffness to 256
`timescale 1ns / 1ps
module overdamping_constant_from_stiffness #(
   parameter int FRAC_BITS = odc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_func,
   input  logic [31:0]                   req_joint_stiffness,
   input  logic [31:0]                   req_device_stiffness,
   input  logic [31:0]                   req_env_stiffness,
   input  logic [31:0]                   req_target_stiffness,
   output logic                          rsp_valid,
   output logic [31:0]                   rsp_damping_factor,
   output logic [2:0]                    rsp_status,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [odc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import odc_pkg::*;

   localparam int TW = 2 * FRAC_BITS;
   localparam int QW = 33 + TW;
   localparam int XW = (QW + 1 > 69) ? QW + 1 : 69;
   localparam logic [63:0] ONE_THIRD  = (64'd1 << TW) / 64'd3;
   localparam logic [63:0] TWO_THIRDS = (64'd2 << TW) / 64'd3;
   localparam logic [XW-1:0] X_ONE = XW'(1) << TW;

   // configuration register
   logic [31:0] min_stiff_ff;
   logic        csr_write;

   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign busy      = 1'b0;
   assign prdata    = (paddr[2] == REG_MIN_STIFFNESS) ? min_stiff_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_stiff_ff <= MIN_STIFF_RESET;
      end else if (csr_write && paddr[2] == REG_MIN_STIFFNESS) begin
         min_stiff_ff <= pwdata;
      end
   end

   // stage 1: input register
   logic        s1_valid_ff;
   logic [1:0]  s1_func_ff;
   logic [31:0] s1_stiff_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      s1_func_ff     <= req_func;
      s1_stiff_ff[0] <= req_joint_stiffness;
      s1_stiff_ff[1] <= req_device_stiffness;
      s1_stiff_ff[2] <= req_env_stiffness;
      s1_stiff_ff[3] <= req_target_stiffness;
   end

   // stage 2: checks, flags and pairwise products
   ctl_type     s2_ctl_in, s2_ctl_ff;
   logic [2:0]  fin;
   logic [31:0] u [3];
   logic [63:0] s2_p01_ff, s2_p12_ff, s2_p02_ff;
   logic [31:0] s2_u2_ff, s2_t_ff;
   logic [2:0]  s2_fin_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fin[i] = s1_stiff_ff[i] != STIFF_INF;
         u[i]   = fin[i] ? s1_stiff_ff[i] : 32'd1;
      end
      s2_ctl_in.valid    = s1_valid_ff;
      s2_ctl_in.func     = s1_func_ff;
      s2_ctl_in.any_zero = (s1_stiff_ff[0] == 32'd0) || (s1_stiff_ff[1] == 32'd0)
                           || (s1_stiff_ff[2] == 32'd0);
      s2_ctl_in.comb_inf = fin == 3'b000;
      s2_ctl_in.t_inf    = s1_stiff_ff[3] == STIFF_INF;
      s2_ctl_in.t_zero   = s1_stiff_ff[3] == 32'd0;
      priority if (s1_stiff_ff[0] < min_stiff_ff) s2_ctl_in.status = ST_JOINT;
      else if (s1_stiff_ff[1] < min_stiff_ff)     s2_ctl_in.status = ST_DEVICE;
      else if (s1_stiff_ff[2] < min_stiff_ff)     s2_ctl_in.status = ST_ENV;
      else if (s1_stiff_ff[3] < min_stiff_ff)     s2_ctl_in.status = ST_TARGET;
      else if (s1_func_ff == FUNC_UNKNOWN)        s2_ctl_in.status = ST_FUNC;
      else                                        s2_ctl_in.status = ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else begin
         s2_ctl_ff <= s2_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_p01_ff <= u[0] * u[1];
      s2_p12_ff <= u[1] * u[2];
      s2_p02_ff <= u[0] * u[2];
      s2_u2_ff  <= u[2];
      s2_t_ff   <= s1_stiff_ff[3];
      s2_fin_ff <= fin;
   end

   // stage 3: partial products of the triple product, sum of pair products
   ctl_type     s3_ctl_ff;
   logic [63:0] s3_pl_ff, s3_ph_ff;
   logic [65:0] s3_q_ff;
   logic [31:0] s3_t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff <= '0;
      end else begin
         s3_ctl_ff <= s2_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_pl_ff <= s2_p01_ff[31:0] * s2_u2_ff;
      s3_ph_ff <= s2_p01_ff[63:32] * s2_u2_ff;
      s3_q_ff  <= (s2_fin_ff[0] ? {2'b00, s2_p12_ff} : 66'd0)
                + (s2_fin_ff[1] ? {2'b00, s2_p02_ff} : 66'd0)
                + (s2_fin_ff[2] ? {2'b00, s2_p01_ff} : 66'd0);
      s3_t_ff  <= s2_t_ff;
   end

   // series divider: comb = floor(P * 2^32 / Q), one quotient bit per stage
   ctl_type     d1_ctl_ff [65];
   logic [65:0] d1_rem_ff  [65];
   logic [63:0] d1_low_ff  [65];
   logic [63:0] d1_quot_ff [65];
   logic [65:0] d1_den_ff  [65];
   logic [31:0] d1_t_ff    [65];
   logic [95:0] p_full;

   assign p_full = {s3_ph_ff, 32'd0} + {32'd0, s3_pl_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ctl_ff[0] <= '0;
      end else begin
         d1_ctl_ff[0] <= s3_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      d1_rem_ff[0]  <= {2'b00, p_full[95:32]};
      d1_low_ff[0]  <= {p_full[31:0], 32'd0};
      d1_quot_ff[0] <= 64'd0;
      d1_den_ff[0]  <= s3_q_ff;
      d1_t_ff[0]    <= s3_t_ff;
   end

   for (genvar k = 0; k < 64; k++) begin : g_div1
      logic [66:0] trial;
      logic        take;

      // shift in the next numerator bit, subtract when it fits
      assign trial = {d1_rem_ff[k], d1_low_ff[k][63]};
      assign take  = trial >= {1'b0, d1_den_ff[k]};

      always_ff @(posedge clock) begin
         if (reset) begin
            d1_ctl_ff[k+1] <= '0;
         end else begin
            d1_ctl_ff[k+1] <= d1_ctl_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         d1_rem_ff[k+1]  <= take ? 66'(trial - {1'b0, d1_den_ff[k]}) : trial[65:0];
         d1_low_ff[k+1]  <= {d1_low_ff[k][62:0], 1'b0};
         d1_quot_ff[k+1] <= {d1_quot_ff[k][62:0], take};
         d1_den_ff[k+1]  <= d1_den_ff[k];
         d1_t_ff[k+1]    <= d1_t_ff[k];
      end
   end

   // kappa divider: floor((m * comb * 2^TW >> 32) / target)
   ctl_type       d2_ctl_ff  [QW+1];
   logic [31:0]   d2_rem_ff  [QW+1];
   logic [QW-1:0] d2_num_ff  [QW+1];
   logic [QW-1:0] d2_quot_ff [QW+1];
   logic [31:0]   d2_t_ff    [QW+1];
   logic [64:0]      comb_m;
   logic [64+TW:0]   comb_full;

   assign comb_m    = (d1_ctl_ff[64].func == FUNC_HINF) ? {d1_quot_ff[64], 1'b0}
                                                        : {1'b0, d1_quot_ff[64]};
   assign comb_full = {comb_m, TW'(0)};

   always_ff @(posedge clock) begin
      if (reset) begin
         d2_ctl_ff[0] <= '0;
      end else begin
         d2_ctl_ff[0] <= d1_ctl_ff[64];
      end
   end

   always_ff @(posedge clock) begin
      d2_rem_ff[0]  <= 32'd0;
      d2_num_ff[0]  <= comb_full[64+TW:32];
      d2_quot_ff[0] <= '0;
      d2_t_ff[0]    <= d1_t_ff[64];
   end

   for (genvar k = 0; k < QW; k++) begin : g_div2
      logic [32:0] trial;
      logic        take;

      assign trial = {d2_rem_ff[k], d2_num_ff[k][QW-1]};
      assign take  = trial >= {1'b0, d2_t_ff[k]};

      always_ff @(posedge clock) begin
         if (reset) begin
            d2_ctl_ff[k+1] <= '0;
         end else begin
            d2_ctl_ff[k+1] <= d2_ctl_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         d2_rem_ff[k+1]  <= take ? 32'(trial - {1'b0, d2_t_ff[k]}) : trial[31:0];
         d2_num_ff[k+1]  <= {d2_num_ff[k][QW-2:0], 1'b0};
         d2_quot_ff[k+1] <= {d2_quot_ff[k][QW-2:0], take};
         d2_t_ff[k+1]    <= d2_t_ff[k];
      end
   end

   // square root operand with special cases and saturation
   ctl_type       xc;
   logic [XW-1:0] x_full;
   logic          x_sat;
   logic [67:0]   x_val;

   assign xc = d2_ctl_ff[QW];

   always_comb begin
      x_full = X_ONE;
      x_sat  = 1'b0;
      priority if (xc.comb_inf) begin
         if (xc.t_inf) begin
            x_full = X_ONE + XW'((xc.func == FUNC_HINF) ? TWO_THIRDS : ONE_THIRD);
         end else begin
            x_sat = 1'b1;
         end
      end else if (xc.t_inf || xc.any_zero) begin
         x_full = X_ONE;
      end else if (xc.t_zero) begin
         x_sat = 1'b1;
      end else begin
         x_full = X_ONE + XW'(d2_quot_ff[QW]);
      end
      x_val = (x_sat || x_full[XW-1:68] != '0) ? {68{1'b1}} : x_full[67:0];
   end

   // square root, one root bit per stage from the top
   ctl_type     sq_ctl_ff  [35];
   logic [69:0] sq_rem_ff  [35];
   logic [33:0] sq_root_ff [35];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ctl_ff[0] <= '0;
      end else begin
         sq_ctl_ff[0] <= xc;
      end
   end

   always_ff @(posedge clock) begin
      sq_rem_ff[0]  <= {2'b00, x_val};
      sq_root_ff[0] <= 34'd0;
   end

   for (genvar k = 0; k < 34; k++) begin : g_sqrt
      localparam int B = 33 - k;
      logic [69:0] trial;
      logic        take;

      // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
      assign trial = ({36'd0, sq_root_ff[k]} << (B + 1)) + (70'd1 << (2 * B));
      assign take  = sq_rem_ff[k] >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_ctl_ff[k+1] <= '0;
         end else begin
            sq_ctl_ff[k+1] <= sq_ctl_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         sq_rem_ff[k+1]  <= take ? sq_rem_ff[k] - trial : sq_rem_ff[k];
         sq_root_ff[k+1] <= take ? (sq_root_ff[k] | (34'd1 << B)) : sq_root_ff[k];
      end
   end

   // final form per criterion, saturation and output register
   ctl_type     oc;
   logic [33:0] res;
   logic        rsp_valid_ff;
   logic [31:0] rsp_damping_ff;
   logic [2:0]  rsp_status_ff;
   logic [31:0] damping_in;

   assign oc = sq_ctl_ff[34];

   always_comb begin
      if (oc.func == FUNC_BENADY) begin
         res = sq_root_ff[34];
      end else begin
         res = (sq_root_ff[34] - (34'd1 << FRAC_BITS)) >> 1;
      end
      if (oc.status != ST_OK) begin
         damping_in = 32'd0;
      end else if (res[33:32] != 2'b00) begin
         damping_in = 32'hFFFF_FFFF;
      end else begin
         damping_in = res[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= oc.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_damping_ff <= damping_in;
      rsp_status_ff  <= oc.status;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_damping_factor = rsp_damping_ff;
   assign rsp_status         = rsp_status_ff;

   // checks
`include "overdamping_constant_from_stiffness_macros.svh"

   `ODC_ASSERT_NEXT(a_accept_enters, clock, reset, start && !busy, s1_valid_ff)
   `ODC_ASSERT_NOW(a_error_zero, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_damping_factor == 32'd0)
   `ODC_ASSERT_NOW(a_status_range, clock, reset, rsp_valid, rsp_status <= ST_FUNC)

endmodule
